@@ sv/b64d_pkg.sv @@
// Shared types, constants and the character lookup for the Base64 decoder.
// No dependencies; every other file of the decoder imports this package.
package b64d_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_PUSH    = 3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LEN  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        t_status    status;
        logic       last_result;
    } t_result;

    typedef struct packed {
        logic [1:0]             cnt;
        t_result [MAX_PUSH-1:0] res;
    } t_push;

    // Bit 6 of the returned value is set for a character outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = 7'h40;
        if (c >= 8'd65 && c <= 8'd90) begin
            v = 7'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            v = 7'(c - 8'd71);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            v = 7'(c + 8'd4);
        end else if (c == 8'd43) begin
            v = 7'd62;
        end else if (c == 8'd47) begin
            v = 7'd63;
        end
        return v;
    endfunction

endpackage

@@ sv/base64_decoder.sv @@
// Base64 decoder top level: character decode, quartet assembly and the result
// queue. Depends on b64d_pkg and b64d_queue.
// A character's results are pushed into the registered result queue when it is accepted.
// One character request per cycle; results leave one per cycle while i_ready is high.
// A quartet pushes up to three results, and requests stall only when the
// eight-entry result queue lacks room for three. Reset is synchronous, active low.
module base64_decoder
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_status,
    output logic       o_last_result
);

    logic [23:0] r_acc, n_acc;
    logic [1:0]  r_pos, n_pos;
    logic        r_pad_third, n_pad_third;
    logic        r_disc, n_disc;

    logic        accept;
    logic        is_pad;
    logic [6:0]  sx;
    logic [5:0]  v;
    logic [23:0] acc_shift;
    logic [1:0]  drop;
    t_push       push;
    t_result     head;

    assign accept = i_valid && o_ready;
    assign is_pad = (i_char_code == PAD_CHAR);
    assign sx     = sextet_of(i_char_code);
    assign v      = is_pad ? 6'd0 : sx[5:0];
    assign acc_shift = {r_acc[17:0], v};

    always_comb begin
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_pad_third = r_pad_third;
        n_disc      = r_disc;
        push        = '0;
        drop        = 2'd0;
        if (accept) begin
            if (r_disc || (!is_pad && sx[6])) begin
                if (i_last_char) begin
                    push.cnt = 2'd1;
                    push.res[0].status = (r_pos != 2'd3) ? ST_BAD_LEN : ST_BAD_CHAR;
                    push.res[0].last_result = 1'b1;
                    n_acc       = '0;
                    n_pos       = 2'd0;
                    n_pad_third = 1'b0;
                    n_disc      = 1'b0;
                end else begin
                    n_pos  = r_pos + 2'd1;
                    n_disc = 1'b1;
                end
            end else if (i_last_char && r_pos != 2'd3) begin
                push.cnt = 2'd1;
                push.res[0].status = ST_BAD_LEN;
                push.res[0].last_result = 1'b1;
                n_acc       = '0;
                n_pos       = 2'd0;
                n_pad_third = 1'b0;
            end else if (r_pos != 2'd3) begin
                n_acc = acc_shift;
                n_pos = r_pos + 2'd1;
                if (r_pos == 2'd2) begin
                    n_pad_third = is_pad;
                end
            end else begin
                if (i_last_char) begin
                    drop = 2'(r_pad_third) + 2'(is_pad);
                end
                push.cnt = 2'd3 - drop;
                for (int k = 0; k < MAX_PUSH; k++) begin
                    push.res[k].data_byte = acc_shift[23 - 8*k -: 8];
                    push.res[k].status    = ST_OK;
                    push.res[k].last_result = i_last_char && (2'(k + 1) == push.cnt);
                end
                n_acc       = '0;
                n_pos       = 2'd0;
                n_pad_third = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pos       <= 2'd0;
            r_pad_third <= 1'b0;
            r_disc      <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_pos       <= n_pos;
            r_pad_third <= n_pad_third;
            r_disc      <= n_disc;
        end
    end

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_head  (head)
    );

    assign o_data_byte   = head.data_byte;
    assign o_status      = head.status;
    assign o_last_result = head.last_result;

endmodule

@@ sv/b64d_queue.sv @@
// Result queue of the Base64 decoder: takes up to three results a cycle and
// hands out one result a cycle while i_ready is high. Depends on b64d_pkg.
module b64d_queue
    import b64d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_head
);

    t_result [QUEUE_DEPTH-1:0] r_mem;
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_count <= QUEUE_CW'(QUEUE_DEPTH - MAX_PUSH));

    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_AW'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + QUEUE_AW'(pop);
        n_count  = r_count + QUEUE_CW'(i_push.cnt) - QUEUE_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (2'(k) < i_push.cnt) begin
                r_mem[r_wr_ptr + QUEUE_AW'(k)] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("Result queue holds more entries than its depth.");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_room)
        else $error("Results were pushed while the queue had no room.");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QUEUE_AW'(r_wr_ptr - r_rd_ptr) == QUEUE_AW'(r_count))
        else $error("Queue pointers disagree with the entry count.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && i_push.cnt == 2'd0) |=> (r_count == '0))
        else $error("Empty queue gained entries without a push.");

endmodule

@@ test/tb_base64_decoder.sv @@
// Self-checking testbench for base64_decoder: a scoreboard predicts the decoded
// bytes and status codes for every accepted request and checks each result.
// Depends on b64d_pkg for the result and status types.
`timescale 1ns / 1ps

module tb_base64_decoder
    import b64d_pkg::*;
();

    typedef enum int {
        MSG_GOOD,
        MSG_BAD_CHAR,
        MSG_BAD_LEN,
        MSG_NOISE
    } t_msg_kind;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_char_code;
    logic       i_last_char;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_data_byte;
    logic [1:0] o_status;
    logic       o_last_result;

    int requests_counted;
    bit quiet_phase;
    bit long_hold_req;

    base64_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_code   (i_char_code),
        .i_last_char   (i_last_char),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data_byte   (o_data_byte),
        .o_status      (o_status),
        .o_last_result (o_last_result)
    );

    // Bit 6 flags a character outside the alphabet.
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [6:0] v;
        case (1'b1)
            (c >= "A" && c <= "Z"): v = {1'b0, 6'(c - 8'd65)};
            (c >= "a" && c <= "z"): v = {1'b0, 6'(c - 8'd97 + 8'd26)};
            (c >= "0" && c <= "9"): v = {1'b0, 6'(c - 8'd48 + 8'd52)};
            (c == "+"):             v = 7'd62;
            (c == "/"):             v = 7'd63;
            default:                v = 7'h40;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] alphabet_char(input int unsigned idx);
        if (idx < 26) return 8'(65 + idx);
        if (idx < 52) return 8'(97 + idx - 26);
        if (idx < 62) return 8'(48 + idx - 52);
        if (idx == 62) return "+";
        return "/";
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        logic [6:0] s;
        do begin
            c = 8'($urandom_range(0, 255));
            s = char_sextet(c);
        end while (!s[6] || c == PAD_CHAR);
        return c;
    endfunction

    class b64_scoreboard;
        t_result     decoded_q[$];
        logic [23:0] acc;
        logic [1:0]  pos;
        logic        pad_third;
        logic        discarding;
        int          errors;

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            acc        = '0;
            pos        = '0;
            pad_third  = 1'b0;
            discarding = 1'b0;
        endfunction

        function void push_result(logic [7:0] b, t_status st, logic lr);
            t_result r;
            r.data_byte   = b;
            r.status      = st;
            r.last_result = lr;
            decoded_q.push_back(r);
        endfunction

        // Returns 0 when a pad or alphabet character is swallowed while discarding.
        function bit decode_char(logic [7:0] c, logic last);
            logic       is_pad;
            logic [6:0] v;
            int         cnt;
            is_pad = (c == PAD_CHAR);
            v      = is_pad ? 7'd0 : char_sextet(c);
            if (!is_pad && v[6]) begin
                discarding = 1'b1;
            end
            if (discarding) begin
                if (last) begin
                    push_result(8'h00, (pos != 2'd3) ? ST_BAD_LEN : ST_BAD_CHAR, 1'b1);
                    clear_state();
                    return 1;
                end
                pos = pos + 2'd1;
                return (!is_pad && v[6]);
            end
            if (last && pos != 2'd3) begin
                push_result(8'h00, ST_BAD_LEN, 1'b1);
                clear_state();
                return 1;
            end
            acc = {acc[17:0], v[5:0]};
            if (pos == 2'd2) begin
                pad_third = is_pad;
            end
            if (pos != 2'd3) begin
                pos = pos + 2'd1;
                return 1;
            end
            cnt = 3;
            if (last) begin
                cnt = cnt - int'(pad_third) - int'(is_pad);
            end
            for (int k = 0; k < cnt; k++) begin
                push_result(acc[16 - 8 * k +: 8], ST_OK, last && (k + 1 == cnt));
            end
            clear_state();
            return 1;
        endfunction

        function void check_output(logic [7:0] b, logic [1:0] st, logic lr);
            t_result r;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got byte %02h status %0d last %0b",
                         $time, b, st, lr);
                errors++;
                return;
            end
            r = decoded_q.pop_front();
            if (r.data_byte !== b) begin
                $display("%0t: data_byte mismatch, expected %02h, got %02h",
                         $time, r.data_byte, b);
                errors++;
            end
            if (r.status !== st) begin
                $display("%0t: status mismatch, expected %0d, got %0d", $time, r.status, st);
                errors++;
            end
            if (r.last_result !== lr) begin
                $display("%0t: last_result mismatch, expected %0b, got %0b",
                         $time, r.last_result, lr);
                errors++;
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    b64_scoreboard sb;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = (!quiet_phase && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (sb.decode_char(c, last)) begin
            requests_counted++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_message(input t_msg_kind kind);
        logic [7:0] msg[$];
        int         len;
        int         pad_mode;
        int         idx;
        case (kind)
            MSG_GOOD, MSG_BAD_CHAR: begin
                len = 4 * (($urandom_range(0, 3) == 0) ? $urandom_range(3, 6)
                                                       : $urandom_range(1, 2));
                for (int i = 0; i < len; i++) begin
                    if (i < len - 4 && $urandom_range(0, 15) == 0) begin
                        msg.push_back(PAD_CHAR);
                    end else begin
                        msg.push_back(alphabet_char($urandom_range(0, 63)));
                    end
                end
                pad_mode = $urandom_range(0, 3);
                if (pad_mode == 1 || pad_mode == 2) msg[len - 1] = PAD_CHAR;
                if (pad_mode == 2 || pad_mode == 3) msg[len - 2] = PAD_CHAR;
                if (kind == MSG_BAD_CHAR) begin
                    idx = $urandom_range(0, len - 1);
                    msg[idx] = bad_char();
                end
            end
            MSG_BAD_LEN: begin
                len = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        msg.push_back(PAD_CHAR);
                    end else if ($urandom_range(0, 9) == 0) begin
                        msg.push_back(bad_char());
                    end else begin
                        msg.push_back(alphabet_char($urandom_range(0, 63)));
                    end
                end
            end
            default: begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    msg.push_back(8'($urandom_range(0, 255)));
                end
            end
        endcase
        for (int i = 0; i < msg.size(); i++) begin
            if (kind == MSG_NOISE && i < msg.size() - 1) begin
                send_char(msg[i], $urandom_range(0, 7) == 0);
            end else begin
                send_char(msg[i], i == msg.size() - 1);
            end
        end
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        i_ready    = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = 79;
                i_ready      <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_ready   <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_output(o_data_byte, o_status, o_last_result);
        end
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int pick;
        sb               = new();
        requests_counted = 0;
        quiet_phase      = 1'b0;
        long_hold_req    = 1'b0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_char_code      = 8'h00;
        i_last_char      = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_text("TWFu");
        send_text("TQ==");
        send_text("A=A=+/=z");
        send_text("Zz");
        send_char(8'h00, 1'b0);
        send_char("A", 1'b0);
        send_char("A", 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h80, 1'b1);

        long_hold_req = 1'b1;
        while (requests_counted < 460) begin
            if (requests_counted > 400) begin
                quiet_phase = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_message(MSG_GOOD);
            end else if (pick == 7) begin
                send_message(MSG_BAD_CHAR);
            end else if (pick == 8) begin
                send_message(MSG_BAD_LEN);
            end else begin
                send_message(MSG_NOISE);
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
